@@ hw/rtl/linear_probing_hash_table_core_defines.svh @@
// Assertion macros for the hash table core.
`ifndef LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHT_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(label, clk, rst_n, prop, msg)
`define LPHT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/lpht_pkg.sv @@
// Shared types and codes of the hash table core.
package lpht_pkg;
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY_KEY = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [31:0] found_value;
	} rsp_t;
endpackage

@@ hw/rtl/lpht_stream_if.sv @@
// Valid/ready channel carrying one payload.
interface lpht_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/linear_probing_hash_table_core.sv @@
// Linear probing hash table core, top level.
// Insert, search and delete on up to TABLE_DEPTH slots. The front takes a
// beat per cycle, while not full, into a two-entry queue after hashing the key;
// the back probes one slot at a time. Insert steps over used slots by their
// used bits alone; search and delete read each slot visited from memory
// and then compare its key.
module linear_probing_hash_table_core #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	lpht_stream_if.sink   in_ch,
	lpht_stream_if.source out_ch
);
	import lpht_pkg::*;
	localparam int AW = $clog2(TABLE_DEPTH);
	logic          q_valid, q_ready;
	req_t          q_req;
	logic [AW-1:0] q_home;

	lpht_front #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_req(in_ch.data), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.q_home(q_home));
	lpht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_req(q_req), .q_home(q_home), .out_valid(out_ch.valid),
		.out_ready(out_ch.ready), .out_rsp(out_ch.data));
endmodule

@@ hw/rtl/lpht_ram.sv @@
// Generic single-port RAM with registered read.
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/lpht_front.sv @@
// Front: key normalize, home slot hash, queue to the back.
module lpht_front #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_BYTES = 8,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lpht_pkg::req_t       in_req,
	output logic                 q_valid,
	input  logic                 q_ready,
	output lpht_pkg::req_t       q_req,
	output logic [AW-1:0]        q_home
);
	import lpht_pkg::*;
	localparam int QD = 2;
	req_t          req_q  [QD];
	logic [AW-1:0] home_q [QD];
	logic [1:0]    cnt_q;
	logic          wp_q, rp_q;
	logic [63:0]   norm;
	logic [11:0]   sum;
	logic          live;
	logic          push, pop;

	always_comb begin
		norm = '0;
		sum = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (in_req.key[8*i +: 8] == 8'd0) live = 1'b0;
			if (live) begin
				norm[8*i +: 8] = in_req.key[8*i +: 8];
				sum = sum + {4'd0, in_req.key[8*i +: 8]};
			end
		end
	end

	assign in_ready = cnt_q != 2'(QD);
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_req = req_q[rp_q];
	assign q_home = home_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			req_q[wp_q] <= '{op: in_req.op, key: norm, value: in_req.value};
			home_q[wp_q] <= AW'(32'(sum) % TABLE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ hw/rtl/lpht_back.sv @@
// Back: probe sequencer over the slot memories.
module lpht_back #(
	parameter int TABLE_DEPTH = 16,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  lpht_pkg::req_t q_req,
	input  logic [AW-1:0]  q_home,
	output logic           out_valid,
	input  logic           out_ready,
	output lpht_pkg::rsp_t out_rsp
);
	import lpht_pkg::*;
	`include "linear_probing_hash_table_core_defines.svh"
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD = 2'd1;
	localparam logic [1:0] S_CHK = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0]       state_q;
	logic [TABLE_DEPTH-1:0] used_q;
	req_t             req_q;
	logic [AW-1:0]    idx_q;
	logic [AW:0]      n_q;
	rsp_t             rsp_q;
	logic             we_k;
	logic [63:0]      rkey;
	logic [31:0]      rval;
	logic [AW-1:0]    nxt;

	assign nxt = (32'(idx_q) == TABLE_DEPTH - 1) ? '0 : idx_q + 1'b1;
	assign we_k = state_q == S_RD && req_q.op == OP_INSERT && !used_q[idx_q];

	lpht_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key (
		.clk(clk), .we(we_k), .addr(idx_q), .wdata(req_q.key), .rdata(rkey));
	lpht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val (
		.clk(clk), .we(we_k), .addr(idx_q), .wdata(req_q.value), .rdata(rval));

	assign q_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			req_q <= '0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					req_q <= q_req;
					idx_q <= q_home;
					n_q <= '0;
					rsp_q <= '{status: ST_NOT_FOUND, slot: 4'd0, found_value: 32'd0};
					if (q_req.op == OP_UNUSED) state_q <= S_OUT;
					else if (q_req.key == 64'd0) begin
						rsp_q.status <= ST_EMPTY_KEY;
						state_q <= S_OUT;
					end else state_q <= S_RD;
				end
				S_RD: begin
					if (32'(n_q) == TABLE_DEPTH) begin
						if (req_q.op == OP_INSERT) rsp_q.status <= ST_FULL;
						state_q <= S_OUT;
					end else if (!used_q[idx_q]) begin
						if (req_q.op == OP_INSERT) begin
							used_q[idx_q] <= 1'b1;
							rsp_q.status <= ST_OK;
							rsp_q.slot <= 4'(32'(idx_q));
						end
						state_q <= S_OUT;
					end else if (req_q.op == OP_INSERT) begin
						idx_q <= nxt;
						n_q <= n_q + 1'b1;
					end else state_q <= S_CHK;
				end
				S_CHK: begin
					if (rkey == req_q.key) begin
						rsp_q.status <= ST_OK;
						rsp_q.slot <= 4'(32'(idx_q));
						rsp_q.found_value <= rval;
						if (req_q.op == OP_DELETE) used_q[idx_q] <= 1'b0;
						state_q <= S_OUT;
					end else begin
						idx_q <= nxt;
						n_q <= n_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LPHT_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "result changed while stalled")
	`LPHT_ASSERT(a_no_take, clk, arst_n, state_q != S_IDLE |-> !q_ready, "queue popped while busy")
	`LPHT_ASSERT(a_probe_bound, clk, arst_n, 32'(n_q) <= TABLE_DEPTH, "probe count overran table")
	`LPHT_ASSERT(a_ins_sets, clk, arst_n, we_k |=> used_q[$past(idx_q)], "insert did not mark slot")
endmodule

@@ tb/tb_linear_probing_hash_table_core.sv @@
// Testbench for the linear probing hash table core: directed and random traffic checked against a table model.
`timescale 1ns / 100ps
module tb_linear_probing_hash_table_core;
	import lpht_pkg::*;

	localparam int DEPTH = 16;
	localparam int N_RAND = 1650;
	localparam int CYCLE_LIMIT = 400000;

	class table_scoreboard;
		bit          used[DEPTH];
		logic [63:0] keys[DEPTH];
		logic [31:0] vals[DEPTH];
		rsp_t        pending[$];
		int          errors;

		function void reset_table();
			foreach (used[i]) used[i] = 0;
			pending.delete();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void note_request(req_t r);
			rsp_t        e;
			logic [63:0] k;
			logic [7:0]  b;
			int          sum;
			int          idx;
			int          n;
			bit          stop;
			k = '0;
			sum = 0;
			stop = 0;
			for (int i = 0; i < 8; i++) begin
				b = r.key[8*i +: 8];
				if (b == 0) stop = 1;
				if (!stop) begin
					k[8*i +: 8] = b;
					sum += b;
				end
			end
			idx = sum % DEPTH;
			e.status = ST_NOT_FOUND;
			e.slot = '0;
			e.found_value = '0;
			if (r.op == OP_UNUSED) begin
				e.status = ST_NOT_FOUND;
			end else if (k == 0) begin
				e.status = ST_EMPTY_KEY;
			end else if (r.op == OP_INSERT) begin
				e.status = ST_FULL;
				for (n = 0; n < DEPTH; n++) begin
					if (!used[idx]) begin
						used[idx] = 1;
						keys[idx] = k;
						vals[idx] = r.value;
						e.status = ST_OK;
						e.slot = idx[3:0];
						break;
					end
					idx = (idx + 1) % DEPTH;
				end
			end else begin
				for (n = 0; n < DEPTH; n++) begin
					if (!used[idx]) break;
					if (keys[idx] == k) begin
						e.status = ST_OK;
						e.slot = idx[3:0];
						e.found_value = vals[idx];
						if (r.op == OP_DELETE) used[idx] = 0;
						break;
					end
					idx = (idx + 1) % DEPTH;
				end
			end
			pending.push_back(e);
		endfunction

		task check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending %h", got));
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status)
				report($sformatf("status got %0d exp %0d", got.status, e.status));
			if (got.slot !== e.slot)
				report($sformatf("slot got %0d exp %0d", got.slot, e.slot));
			if (got.found_value !== e.found_value)
				report($sformatf("value got %h exp %h", got.found_value, e.found_value));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	lpht_stream_if #(.payload_t(req_t)) in_ch ();
	lpht_stream_if #(.payload_t(rsp_t)) out_ch ();
	table_scoreboard sb = new();
	int cycles = 0;
	bit stim_done = 0;
	logic [63:0] key_pool[8];

	linear_probing_hash_table_core #(.TABLE_DEPTH(DEPTH), .KEY_BYTES(8)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	task automatic send_beat(logic [1:0] op, logic [63:0] key, logic [31:0] value);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= '{op: op, key: key, value: value};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		int len;
		k = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return k;
			1: return 64'd0;
			2: return k & 64'hFF00;
			default: begin
				len = $urandom_range(1, 3);
				k = k & ((64'd1 << (8 * len)) - 1);
				if (k[7:0] == 0) k[7:0] = 8'h41;
				return k;
			end
		endcase
	endfunction

	initial begin
		logic [1:0] op;
		logic [63:0] k;
		sb.reset_table();
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_beat(OP_SEARCH, 64'h41, 32'h0);
		send_beat(OP_INSERT, 64'h0, 32'h1);
		send_beat(OP_INSERT, 64'hFFFFFFFFFFFFFFFF, 32'h7FFFFFFF);
		send_beat(OP_INSERT, 64'hFF00FFFFFFFFFFFF, 32'h80000000);
		send_beat(OP_SEARCH, 64'hFFFFFFFFFFFFFFFF, 32'h0);
		send_beat(OP_SEARCH, 64'h00000000000000FF, 32'h0);
		send_beat(OP_INSERT, 64'h21, 32'hFFFFFFFF);
		send_beat(OP_INSERT, 64'h21, 32'h5);
		send_beat(OP_DELETE, 64'h21, 32'h0);
		send_beat(OP_SEARCH, 64'h21, 32'h0);
		send_beat(OP_UNUSED, 64'h41, 32'h0);
		send_beat(OP_UNUSED, 64'h0, 32'h0);
		send_beat(OP_DELETE, 64'h0, 32'h0);
		for (int i = 0; i < 15; i++) send_beat(OP_INSERT, 64'h10, i);
		send_beat(OP_DELETE, 64'h99, 32'h0);
		for (int i = 0; i < 8; i++) key_pool[i] = random_key() | 64'h1;
		for (int i = 0; i < 16; i++) send_beat(OP_DELETE, 64'h10, 32'h0);
		send_beat(OP_DELETE, 64'hFFFFFFFFFFFFFFFF, 32'h0);
		send_beat(OP_DELETE, 64'hFF, 32'h0);
		send_beat(OP_DELETE, 64'h21, 32'h0);
		for (int i = 0; i < N_RAND; i++) begin
			if (i % 200 == 0)
				for (int j = 0; j < 8; j++) key_pool[j] = random_key();
			op = $urandom_range(0, 9) == 0 ? OP_UNUSED : 2'($urandom_range(0, 2));
			k = $urandom_range(0, 3) != 0 ? key_pool[$urandom_range(0, 7)] : random_key();
			send_beat(op, k, $urandom);
		end
		in_ch.valid <= 0;
		stim_done = 1;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			@(negedge clk);
			if (gap > 0) begin
				out_ch.ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
